// ===== rtl/sgb_pkg.sv =====
// ----------------------------------------------------------------------------
// sgb_pkg
// Shared types, codes and arithmetic helpers of the separable Gaussian blur.
// ----------------------------------------------------------------------------
package sgb_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COORD_W    = 11;
    localparam int SC_W       = 14;
    localparam int IDX_W      = 8;
    localparam int COL_W      = 13;
    localparam int ACC_W      = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [1:0] OP_LOAD_WEIGHT = 2'd0;
    localparam logic [1:0] OP_PIXEL       = 2'd1;
    localparam logic [1:0] OP_DRAIN       = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HSTART,
        S_HISSUE,
        S_HWAIT,
        S_CHECK,
        S_VSTART,
        S_VISSUE,
        S_VWAIT
    } state_t;

    typedef struct packed {
        logic             tap_valid;
        logic             tap_first;
        logic             tap_last;
        logic             tap_from_mem;
        logic [IDX_W-1:0] tap_idx;
        logic [COL_W-1:0] tap_col;
        logic [IDX_W-1:0] tap_wt;
        logic             wt_write;
        logic             win_write;
        logic [IDX_W-1:0] win_idx;
        logic             row_write;
        logic [IDX_W-1:0] wr_row;
        logic [COL_W-1:0] wr_col;
        logic             out_load;
        logic             frame_end;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic out_free;
    } status_t;

    function automatic logic [SAMPLE_W-1:0] round_sat(input logic [ACC_W-1:0] acc);
        logic [ACC_W:0] s;
        s = {1'b0, acc} + (ACC_W+1)'(32768);
        if (|s[ACC_W:32])
            return {SAMPLE_W{1'b1}};
        else
            return s[31:16];
    endfunction

endpackage

// ===== rtl/sgb_in_if.sv =====
// ----------------------------------------------------------------------------
// sgb_in_if
// Input item channel: weight loads, pixels and drains.
// ----------------------------------------------------------------------------
interface sgb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [4:0]  tap_index;
    logic [15:0] weight_value;
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
    logic [15:0] alpha_in;

    modport source (output valid, operation, tap_index, weight_value,
                    red_in, green_in, blue_in, alpha_in, input ready);
    modport sink (input valid, operation, tap_index, weight_value,
                  red_in, green_in, blue_in, alpha_in, output ready);
endinterface

// ===== rtl/sgb_out_if.sv =====
// ----------------------------------------------------------------------------
// sgb_out_if
// Result channel: blurred RGBA pixels with a frame end mark.
// ----------------------------------------------------------------------------
interface sgb_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic [15:0] alpha_out;
    logic        frame_end;

    modport source (output valid, red_out, green_out, blue_out, alpha_out,
                    frame_end, input ready);
    modport sink (input valid, red_out, green_out, blue_out, alpha_out,
                  frame_end, output ready);
endinterface

// ===== rtl/sgb_datapath.sv =====
// ----------------------------------------------------------------------------
// sgb_datapath
// Weight table, pixel window, row buffer, multiply-accumulate pipe and
// output register.
// ----------------------------------------------------------------------------
module sgb_datapath #(
    parameter int MAX_RADIUS = 8,
    parameter int MAX_WIDTH  = 1024,
    parameter int CHANNELS   = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sgb_pkg::cmd_t           cmd,
    output sgb_pkg::status_t        status,
    input  logic [15:0]             weight_value,
    input  logic [15:0]             red_in,
    input  logic [15:0]             green_in,
    input  logic [15:0]             blue_in,
    input  logic [15:0]             alpha_in,
    sgb_out_if.source               result
);

    localparam int WIN  = 2 * MAX_RADIUS + 1;
    localparam int IW   = $clog2(WIN);
    localparam int CA   = $clog2(MAX_WIDTH);
    localparam int PW   = CHANNELS * sgb_pkg::SAMPLE_W;
    localparam int SW   = sgb_pkg::SAMPLE_W;

    logic [SW-1:0]              wt_reg [WIN];
    logic [PW-1:0]              win_mem [WIN];
    logic [PW-1:0]              row_mem [WIN][MAX_WIDTH];

    logic [PW-1:0]              mem_q_reg;
    logic [PW-1:0]              win_q_reg;
    logic [SW-1:0]              a_wt_reg;
    logic                       a_valid_reg, a_first_reg, a_last_reg, a_from_mem_reg;
    logic [2*SW-1:0]            prod_reg [CHANNELS];
    logic                       b_valid_reg, b_first_reg, b_last_reg;
    logic [sgb_pkg::ACC_W-1:0]  acc_reg [CHANNELS];
    logic                       done_reg;

    logic                       out_valid_reg;
    logic [SW-1:0]              out_ch_reg [4];
    logic                       out_end_reg;

    logic [4*SW-1:0]            pix_all;
    logic [PW-1:0]              pix_in;
    logic [PW-1:0]              a_sample;
    logic [PW-1:0]              packed_res;

    assign pix_all = {alpha_in, blue_in, green_in, red_in};
    assign pix_in  = pix_all[PW-1:0];
    assign a_sample = a_from_mem_reg ? mem_q_reg : win_q_reg;

    always_comb
    begin
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            packed_res[ch*SW +: SW] = sgb_pkg::round_sat(acc_reg[ch]);
        end
    end

    // weight table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN; i++)
            begin
                wt_reg[i] <= '0;
            end
        end
        else if (cmd.wt_write)
        begin
            wt_reg[cmd.win_idx[IW-1:0]] <= weight_value;
        end
    end

    // pixel window
    always_ff @(posedge clk)
    begin
        if (cmd.win_write)
        begin
            win_mem[cmd.win_idx[IW-1:0]] <= pix_in;
        end
        if (cmd.tap_valid)
        begin
            win_q_reg <= win_mem[cmd.tap_idx[IW-1:0]];
            a_wt_reg  <= wt_reg[cmd.tap_wt[IW-1:0]];
        end
    end

    // row buffer of horizontally filtered pixels
    always_ff @(posedge clk)
    begin
        if (cmd.row_write)
        begin
            row_mem[cmd.wr_row[IW-1:0]][CA'(cmd.wr_col)] <= packed_res;
        end
        if (cmd.tap_valid)
        begin
            mem_q_reg <= row_mem[cmd.tap_idx[IW-1:0]][CA'(cmd.tap_col)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            a_valid_reg <= cmd.tap_valid;
            b_valid_reg <= a_valid_reg;
            done_reg    <= b_valid_reg && b_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_first_reg    <= cmd.tap_first;
        a_last_reg     <= cmd.tap_last;
        a_from_mem_reg <= cmd.tap_from_mem;
        b_first_reg    <= a_first_reg;
        b_last_reg     <= a_last_reg;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            if (a_valid_reg)
            begin
                prod_reg[ch] <= a_wt_reg * a_sample[ch*SW +: SW];
            end
            if (b_valid_reg)
            begin
                acc_reg[ch] <= (b_first_reg ? '0 : acc_reg[ch])
                               + sgb_pkg::ACC_W'(prod_reg[ch]);
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_end_reg <= cmd.frame_end;
            for (int ch = 0; ch < 4; ch++)
            begin
                if (ch < CHANNELS)
                    out_ch_reg[ch] <= sgb_pkg::round_sat(acc_reg[ch]);
                else
                    out_ch_reg[ch] <= '0;
            end
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.red_out   = out_ch_reg[0];
    assign result.green_out = out_ch_reg[1];
    assign result.blue_out  = out_ch_reg[2];
    assign result.alpha_out = out_ch_reg[3];
    assign result.frame_end = out_end_reg;

    assign status.done     = done_reg;
    assign status.out_free = !out_valid_reg || result.ready;

endmodule

// ===== rtl/sgb_ctrl.sv =====
// ----------------------------------------------------------------------------
// sgb_ctrl
// Configuration registers, frame counters and the pass sequencer.
// ----------------------------------------------------------------------------
module sgb_ctrl #(
    parameter int MAX_RADIUS = 8,
    parameter int MAX_WIDTH  = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sgb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sgb_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        in_operation,
    input  logic [4:0]                        in_tap_index,
    output sgb_pkg::cmd_t                     cmd,
    input  sgb_pkg::status_t                  status
);

    localparam int WIN = 2 * MAX_RADIUS + 1;
    localparam int CW  = sgb_pkg::COORD_W;
    localparam int SCW = sgb_pkg::SC_W;
    localparam int XW  = sgb_pkg::IDX_W;

    typedef logic signed [SCW-1:0] sc_t;

    sgb_pkg::state_t state_reg, state_next;

    logic [3:0]    radius_reg;
    logic [CW-1:0] width_reg, height_reg;
    logic [CW-1:0] in_col_reg, in_col_next, in_row_reg, in_row_next;
    logic [XW-1:0] in_cmod_reg, in_cmod_next, in_rmod_reg, in_rmod_next;
    logic [CW-1:0] out_col_reg, out_col_next, out_row_reg, out_row_next;
    logic [XW-1:0] out_rmod_reg, out_rmod_next;
    logic [CW-1:0] cur_col_reg, cur_col_next;
    logic [XW-1:0] cur_cmod_reg, cur_cmod_next, cur_rmod_reg, cur_rmod_next;
    logic [CW-1:0] hx_reg, hx_next, hx_end_reg, hx_end_next;
    sc_t           v_reg, v_next;
    logic [XW-1:0] mod_reg, mod_next, t_reg, t_next;

    logic [XW-1:0] rad;
    logic [CW-1:0] w_eff, h_eff;
    sc_t           rad_s, w_s, h_s;
    sc_t           v0, s0, d0, m0, x0, ny, nx;
    logic          out_ready, tap_last, step, at_end;
    logic [CW-1:0] ncol, nrow;
    logic [XW-1:0] nrmod;

    function automatic sc_t to_s(input logic [CW-1:0] x);
        return $signed(SCW'(x));
    endfunction

    function automatic logic [XW-1:0] mod_inc(input logic [XW-1:0] m);
        return (m == XW'(WIN - 1)) ? '0 : m + 1'b1;
    endfunction

    // effective configuration
    always_comb
    begin
        if (32'(radius_reg) > MAX_RADIUS)
            rad = XW'(MAX_RADIUS);
        else
            rad = XW'(radius_reg);
        if (width_reg == '0)
            w_eff = CW'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = width_reg;
        h_eff = (height_reg == '0) ? CW'(1) : height_reg;
        rad_s = $signed(SCW'(rad));
        w_s   = to_s(w_eff);
        h_s   = to_s(h_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 4'd1;
            width_reg  <= CW'(1024);
            height_reg <= CW'(1024);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sgb_pkg::CFG_RADIUS: radius_reg <= cfg_data[3:0];
                sgb_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                sgb_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sgb_pkg::S_IDLE;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_cmod_reg  <= '0;
            in_rmod_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_rmod_reg <= '0;
            cur_col_reg  <= '0;
            cur_cmod_reg <= '0;
            cur_rmod_reg <= '0;
            hx_reg       <= '0;
            hx_end_reg   <= '0;
            v_reg        <= '0;
            mod_reg      <= '0;
            t_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_cmod_reg  <= in_cmod_next;
            in_rmod_reg  <= in_rmod_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_rmod_reg <= out_rmod_next;
            cur_col_reg  <= cur_col_next;
            cur_cmod_reg <= cur_cmod_next;
            cur_rmod_reg <= cur_rmod_next;
            hx_reg       <= hx_next;
            hx_end_reg   <= hx_end_next;
            v_reg        <= v_next;
            mod_reg      <= mod_next;
            t_reg        <= t_next;
        end
    end

    always_comb
    begin
        // output availability
        ny = to_s(out_row_reg) + rad_s;
        if (ny > h_s - 1)
            ny = h_s - 1;
        nx = to_s(out_col_reg) + rad_s;
        if (nx > w_s - 1)
            nx = w_s - 1;
        out_ready = (in_row_reg >= h_eff) || (to_s(in_row_reg) > ny)
                    || ((to_s(in_row_reg) == ny) && (to_s(in_col_reg) > nx));

        ncol  = out_col_reg + 1'b1;
        nrow  = out_row_reg;
        nrmod = out_rmod_reg;
        if (ncol >= w_eff)
        begin
            ncol  = '0;
            nrow  = out_row_reg + 1'b1;
            nrmod = mod_inc(out_rmod_reg);
        end
        at_end = nrow >= h_eff;

        tap_last = (t_reg == (rad << 1));
        v0 = '0;
        s0 = '0;
        d0 = '0;
        m0 = '0;
        x0 = '0;
        step = 1'b0;

        state_next    = state_reg;
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        in_cmod_next  = in_cmod_reg;
        in_rmod_next  = in_rmod_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_rmod_next = out_rmod_reg;
        cur_col_next  = cur_col_reg;
        cur_cmod_next = cur_cmod_reg;
        cur_rmod_next = cur_rmod_reg;
        hx_next       = hx_reg;
        hx_end_next   = hx_end_reg;
        v_next        = v_reg;
        mod_next      = mod_reg;
        t_next        = t_reg;

        cmd       = '0;
        in_ready  = 1'b0;

        case (state_reg)
            sgb_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_operation)
                        sgb_pkg::OP_LOAD_WEIGHT:
                        begin
                            cmd.wt_write = (32'(in_tap_index) < WIN);
                            cmd.win_idx  = XW'(in_tap_index);
                        end
                        sgb_pkg::OP_PIXEL:
                        begin
                            state_next = sgb_pkg::S_CHECK;
                            if (in_row_reg < h_eff)
                            begin
                                cmd.win_write = 1'b1;
                                cmd.win_idx   = in_cmod_reg;
                                cur_col_next  = in_col_reg;
                                cur_cmod_next = in_cmod_reg;
                                cur_rmod_next = in_rmod_reg;
                                x0 = to_s(in_col_reg) - rad_s;
                                if (in_col_reg >= w_eff - 1'b1)
                                begin
                                    hx_next     = (x0 < 0) ? '0 : CW'(x0);
                                    hx_end_next = in_col_reg;
                                    state_next  = sgb_pkg::S_HSTART;
                                end
                                else if (x0 >= 0)
                                begin
                                    hx_next     = CW'(x0);
                                    hx_end_next = CW'(x0);
                                    state_next  = sgb_pkg::S_HSTART;
                                end
                                in_col_next  = in_col_reg + 1'b1;
                                in_cmod_next = mod_inc(in_cmod_reg);
                                if (in_col_reg + 1'b1 >= w_eff)
                                begin
                                    in_col_next  = '0;
                                    in_cmod_next = '0;
                                    in_row_next  = in_row_reg + 1'b1;
                                    in_rmod_next = mod_inc(in_rmod_reg);
                                end
                            end
                        end
                        sgb_pkg::OP_DRAIN:
                        begin
                            state_next = sgb_pkg::S_CHECK;
                        end
                        default: ;
                    endcase
                end
            end

            sgb_pkg::S_HSTART:
            begin
                // first window slot is the current slot stepped back by the distance
                v0 = to_s(hx_reg) - rad_s;
                s0 = (v0 < 0) ? sc_t'(0) : v0;
                d0 = to_s(cur_col_reg) - s0;
                m0 = $signed(SCW'(cur_cmod_reg)) - d0;
                if (m0 < 0)
                    m0 = m0 + sc_t'(WIN);
                v_next     = v0;
                mod_next   = XW'(m0);
                t_next     = '0;
                state_next = sgb_pkg::S_HISSUE;
            end

            sgb_pkg::S_HISSUE:
            begin
                cmd.tap_valid    = 1'b1;
                cmd.tap_first    = (t_reg == '0);
                cmd.tap_last     = tap_last;
                cmd.tap_from_mem = 1'b0;
                cmd.tap_idx      = mod_reg;
                cmd.tap_wt       = t_reg;
                step = (v_reg >= 0) && (v_reg < w_s - 1);
                if (step)
                    mod_next = mod_inc(mod_reg);
                v_next = v_reg + 1;
                t_next = t_reg + 1'b1;
                if (tap_last)
                    state_next = sgb_pkg::S_HWAIT;
            end

            sgb_pkg::S_HWAIT:
            begin
                if (status.done)
                begin
                    cmd.row_write = 1'b1;
                    cmd.wr_row    = cur_rmod_reg;
                    cmd.wr_col    = sgb_pkg::COL_W'(hx_reg);
                    if (hx_reg == hx_end_reg)
                        state_next = sgb_pkg::S_CHECK;
                    else
                    begin
                        hx_next    = hx_reg + 1'b1;
                        state_next = sgb_pkg::S_HSTART;
                    end
                end
            end

            sgb_pkg::S_CHECK:
            begin
                state_next = out_ready ? sgb_pkg::S_VSTART : sgb_pkg::S_IDLE;
            end

            sgb_pkg::S_VSTART:
            begin
                v0 = to_s(out_row_reg) - rad_s;
                s0 = (v0 < 0) ? sc_t'(0) : v0;
                d0 = to_s(out_row_reg) - s0;
                m0 = $signed(SCW'(out_rmod_reg)) - d0;
                if (m0 < 0)
                    m0 = m0 + sc_t'(WIN);
                v_next     = v0;
                mod_next   = XW'(m0);
                t_next     = '0;
                state_next = sgb_pkg::S_VISSUE;
            end

            sgb_pkg::S_VISSUE:
            begin
                cmd.tap_valid    = 1'b1;
                cmd.tap_first    = (t_reg == '0);
                cmd.tap_last     = tap_last;
                cmd.tap_from_mem = 1'b1;
                cmd.tap_idx      = mod_reg;
                cmd.tap_col      = sgb_pkg::COL_W'(out_col_reg);
                cmd.tap_wt       = t_reg;
                step = (v_reg >= 0) && (v_reg < h_s - 1);
                if (step)
                    mod_next = mod_inc(mod_reg);
                v_next = v_reg + 1;
                t_next = t_reg + 1'b1;
                if (tap_last)
                    state_next = sgb_pkg::S_VWAIT;
            end

            sgb_pkg::S_VWAIT:
            begin
                // done pulses once; the sums then hold until the next pass
                if (status.done || (t_reg == '0))
                begin
                    t_next = '0;
                    if (status.out_free)
                    begin
                        cmd.out_load  = 1'b1;
                        cmd.frame_end = at_end;
                        state_next    = sgb_pkg::S_IDLE;
                        if (at_end)
                        begin
                            in_col_next   = '0;
                            in_row_next   = '0;
                            in_cmod_next  = '0;
                            in_rmod_next  = '0;
                            out_col_next  = '0;
                            out_row_next  = '0;
                            out_rmod_next = '0;
                        end
                        else
                        begin
                            out_col_next  = ncol;
                            out_row_next  = nrow;
                            out_rmod_next = nrmod;
                        end
                    end
                end
            end

            default:
            begin
                state_next = sgb_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/separable_gaussian_blur_rgba.sv =====
// ----------------------------------------------------------------------------
// separable_gaussian_blur_rgba
// Separable Gaussian blur with clamp-to-edge for a raster RGBA frame.
// ----------------------------------------------------------------------------
// usage: the item channel carries weight loads, pixels in raster order and
// drains; the result channel carries blurred pixels in raster order, with
// frame_end on the last pixel of a frame. the config port (cfg_we, cfg_index,
// cfg_data) sets radius, width and height; the user must write it only while
// the block is idle; the block itself does not enforce this. a weight load or
// an unknown code leaves the block idle. a pixel runs one horizontal pass per
// filtered column it completes and then, if an output is due, one vertical
// pass; each pass, after a setup state, issues one tap a cycle into the shared
// multiply-accumulate pipe of three stages (tap read, product, accumulate).
// the last pixel of a row adds up to R more horizontal passes; a drain runs
// only a due vertical pass. the row buffer holds 2*MAX_RADIUS+1 filtered rows
// and is read one tap a cycle. after reset the weights are zero, radius 1 and
// frame 1024x1024. a finished result waits in the output register; the next
// item is taken meanwhile; only a new result stalls till the register is free.
// ----------------------------------------------------------------------------
module separable_gaussian_blur_rgba #(
    parameter int MAX_RADIUS = 8,
    parameter int MAX_WIDTH  = 1024,
    parameter int CHANNELS   = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sgb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sgb_pkg::CFG_DATA_W-1:0]    cfg_data,
    sgb_in_if.sink                            item,
    sgb_out_if.source                         result
);

    sgb_pkg::cmd_t    cmd;
    sgb_pkg::status_t status;

    sgb_ctrl #(
        .MAX_RADIUS (MAX_RADIUS),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (item.valid),
        .in_ready     (item.ready),
        .in_operation (item.operation),
        .in_tap_index (item.tap_index),
        .cmd          (cmd),
        .status       (status)
    );

    sgb_datapath #(
        .MAX_RADIUS (MAX_RADIUS),
        .MAX_WIDTH  (MAX_WIDTH),
        .CHANNELS   (CHANNELS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .weight_value (item.weight_value),
        .red_in       (item.red_in),
        .green_in     (item.green_in),
        .blue_in      (item.blue_in),
        .alpha_in     (item.alpha_in),
        .result       (result)
    );

endmodule

// ===== tb/sgb_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sgb_checker
// Watches the item, result and config channels of the blur, predicts every
// blurred pixel from its own copy of the weights, line buffers and counters,
// and compares each result transfer, field by field, with the oldest
// prediction.
// ----------------------------------------------------------------------------
module sgb_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sgb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sgb_pkg::CFG_DATA_W-1:0] cfg_data,
    sgb_in_if                              item,
    sgb_out_if                             result,
    output int                             fail_count,
    output int                             pending,
    output int                             frames_done,
    output int                             results_checked
);

    localparam int TAPS    = 17;
    localparam int MAX_R   = 8;
    localparam int ROW_LEN = 1024;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
        logic        last;
    } blur_px_t;

    blur_px_t    expected_px[$];
    logic [15:0] tap_wt[TAPS];
    logic [63:0] pix_line[TAPS];
    logic [63:0] row_store[TAPS*ROW_LEN];
    logic [3:0]  radius_reg;
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    int          in_col, in_row, out_col, out_row;
    int          mismatches, frame_cnt, checked_cnt;

    function automatic int clamp_to(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int radius_eff();
        return (radius_reg > MAX_R) ? MAX_R : int'(radius_reg);
    endfunction

    function automatic int width_eff();
        if (width_reg == 0)
        begin
            return 1;
        end
        return (width_reg > ROW_LEN) ? ROW_LEN : int'(width_reg);
    endfunction

    function automatic int height_eff();
        return (height_reg == 0) ? 1 : int'(height_reg);
    endfunction

    // round half up, then clip to the 16-bit sample range
    function automatic logic [15:0] round_clip(logic [39:0] acc);
        logic [40:0] biased;
        biased = {1'b0, acc} + 41'd32768;
        biased = biased >> 16;
        return (biased > 41'd65535) ? 16'hFFFF : biased[15:0];
    endfunction

    task automatic report(string what, int exp_val, int got_val);
        mismatches++;
        if (mismatches <= 40)
        begin
            $display("%t mismatch on %s: expected %0d, got %0d", $realtime, what,
                     exp_val, got_val);
        end
    endtask

    task automatic row_filter(int x, int r, int rad, int w);
        logic [63:0] res;
        logic [39:0] acc;
        logic [15:0] s;
        int          col;
        res = '0;
        for (int ch = 0; ch < 4; ch++)
        begin
            acc = '0;
            for (int t = 0; t <= 2 * rad; t++)
            begin
                col = clamp_to(x + t - rad, 0, w - 1);
                s = pix_line[col % TAPS][16*ch +: 16];
                acc = acc + 40'(tap_wt[t]) * 40'(s);
            end
            res[16*ch +: 16] = round_clip(acc);
        end
        row_store[(r % TAPS) * ROW_LEN + x % ROW_LEN] = res;
    endtask

    task automatic take_pixel();
        int rad, w, h, c, r;
        rad = radius_eff();
        w = width_eff();
        h = height_eff();
        c = in_col;
        r = in_row;
        if (r >= h)
        begin
            return;
        end
        pix_line[c % TAPS] = {item.alpha_in, item.blue_in, item.green_in, item.red_in};
        if (c >= w - 1)
        begin
            for (int x = (c >= rad) ? c - rad : 0; x <= c; x++)
            begin
                row_filter(x, r, rad, w);
            end
        end
        else if (c >= rad)
        begin
            row_filter(c - rad, r, rad, w);
        end
        in_col++;
        if (in_col >= w)
        begin
            in_col = 0;
            in_row++;
        end
    endtask

    task automatic column_filter_emit();
        int          rad, w, h, ny, nx, row;
        logic [39:0] acc;
        logic [63:0] v;
        logic [15:0] chan[4];
        blur_px_t    px;
        bit          due;
        rad = radius_eff();
        w = width_eff();
        h = height_eff();
        ny = clamp_to(out_row + rad, 0, h - 1);
        nx = clamp_to(out_col + rad, 0, w - 1);
        due = (in_row >= h) || (in_row > ny) || (in_row == ny && in_col > nx);
        if (!due)
        begin
            return;
        end
        for (int ch = 0; ch < 4; ch++)
        begin
            acc = '0;
            for (int t = 0; t <= 2 * rad; t++)
            begin
                row = clamp_to(out_row + t - rad, 0, h - 1);
                v = row_store[(row % TAPS) * ROW_LEN + out_col % ROW_LEN];
                acc = acc + 40'(tap_wt[t]) * 40'(v[16*ch +: 16]);
            end
            chan[ch] = round_clip(acc);
        end
        out_col++;
        if (out_col >= w)
        begin
            out_col = 0;
            out_row++;
        end
        px.red = chan[0];
        px.green = chan[1];
        px.blue = chan[2];
        px.alpha = chan[3];
        px.last = (out_row >= h);
        if (px.last)
        begin
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
            frame_cnt++;
        end
        expected_px.push_back(px);
    endtask

    task automatic apply_item();
        case (item.operation)
            sgb_pkg::OP_LOAD_WEIGHT:
            begin
                if (item.tap_index < TAPS)
                begin
                    tap_wt[item.tap_index] = item.weight_value;
                end
            end
            sgb_pkg::OP_PIXEL:
            begin
                take_pixel();
                column_filter_emit();
            end
            sgb_pkg::OP_DRAIN:
            begin
                column_filter_emit();
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_result();
        blur_px_t want;
        if (expected_px.size() == 0)
        begin
            report("result transfer with no pixel expected", 0, 1);
            return;
        end
        want = expected_px.pop_front();
        checked_cnt++;
        if (result.red_out !== want.red)
        begin
            report("red_out", want.red, result.red_out);
        end
        if (result.green_out !== want.green)
        begin
            report("green_out", want.green, result.green_out);
        end
        if (result.blue_out !== want.blue)
        begin
            report("blue_out", want.blue, result.blue_out);
        end
        if (result.alpha_out !== want.alpha)
        begin
            report("alpha_out", want.alpha, result.alpha_out);
        end
        if (result.frame_end !== want.last)
        begin
            report("frame_end", want.last, result.frame_end);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                tap_wt[i] = '0;
            end
            radius_reg = 4'd1;
            width_reg = 11'd1024;
            height_reg = 11'd1024;
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
            mismatches = 0;
            frame_cnt = 0;
            checked_cnt = 0;
            expected_px.delete();
            fail_count <= 0;
            pending <= 0;
            frames_done <= 0;
            results_checked <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                check_result();
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    sgb_pkg::CFG_RADIUS: radius_reg = cfg_data[3:0];
                    sgb_pkg::CFG_WIDTH:  width_reg = cfg_data;
                    sgb_pkg::CFG_HEIGHT: height_reg = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (item.valid && item.ready)
            begin
                apply_item();
            end
            fail_count <= mismatches;
            pending <= expected_px.size();
            frames_done <= frame_cnt;
            results_checked <= checked_cnt;
        end
    end

endmodule

// ===== tb/tb_separable_gaussian_blur_rgba.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_separable_gaussian_blur_rgba
// Drives weight loads, frames of pixels, drains and noise into the blur with
// random gaps and result stalls, sweeps radius and frame size between frames,
// and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_separable_gaussian_blur_rgba;

    localparam int RANDOM_ITEMS = 500;
    localparam int IDLE_LIMIT   = 20000;
    localparam int SETTLE       = 300;

    // operation code with no meaning to the block
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [sgb_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [sgb_pkg::CFG_DATA_W-1:0] cfg_data;
    int                             fail_count, pending, frames_done, results_checked;
    int                             items_sent;
    int                             idle_cycles = 0;
    bit                             calm;

    sgb_in_if  in_ch();
    sgb_out_if out_ch();

    separable_gaussian_blur_rgba dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (in_ch),
        .result    (out_ch)
    );

    sgb_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .item            (in_ch),
        .result          (out_ch),
        .fail_count      (fail_count),
        .pending         (pending),
        .frames_done     (frames_done),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // watchdog on cycles with no transfer at all
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: random stall before each transfer
    initial
    begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!(out_ch.valid && out_ch.ready))
            begin
                @(posedge clk);
            end
        end
    end

    task automatic send_item(logic [1:0] op, logic [4:0] tap, logic [15:0] wt,
                             logic [63:0] px);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.operation <= op;
        in_ch.tap_index <= tap;
        in_ch.weight_value <= wt;
        in_ch.red_in <= px[15:0];
        in_ch.green_in <= px[31:16];
        in_ch.blue_in <= px[47:32];
        in_ch.alpha_in <= px[63:48];
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic write_reg(logic [sgb_pkg::CFG_IDX_W-1:0] idx,
                             logic [sgb_pkg::CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // hold the item side until every predicted pixel is out, then let the
    // block finish any drain still in flight
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [15:0] sample(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            2: return 16'($urandom_range(0, 255));
            default: return 16'hFFFF - 16'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [63:0] rand_px(int mode);
        return {sample(mode), sample(mode), sample(mode), sample(mode)};
    endfunction

    function automatic logic [15:0] rand_weight(int mode, int taps);
        int base;
        base = 65536 / taps;
        case (mode)
            0: return 16'(base - $urandom_range(0, base / 8));
            1: return 16'($urandom);
            2: return 16'hFFFF - 16'($urandom_range(0, 4095));
            default: return 16'($urandom_range(0, 3));
        endcase
    endfunction

    task automatic run_frame(int rad, int w, int h, int wmode, int pmode);
        int re, we, he, start, pick;
        re = (rad > 8) ? 8 : rad;
        we = (w == 0) ? 1 : ((w > 1024) ? 1024 : w);
        he = (h == 0) ? 1 : h;
        settle();
        write_reg(sgb_pkg::CFG_RADIUS, sgb_pkg::CFG_DATA_W'(rad));
        write_reg(sgb_pkg::CFG_WIDTH, sgb_pkg::CFG_DATA_W'(w));
        write_reg(sgb_pkg::CFG_HEIGHT, sgb_pkg::CFG_DATA_W'(h));
        cfg_we <= 1'b0;
        for (int t = 0; t <= 2 * re; t++)
        begin
            send_item(sgb_pkg::OP_LOAD_WEIGHT, 5'(t), rand_weight(wmode, 2 * re + 1),
                      rand_px(0));
        end
        start = frames_done;
        for (int i = 0; i < we * he; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 2)
            begin
                send_item(OP_UNUSED, 5'($urandom), 16'($urandom), rand_px(0));
            end
            else if (pick < 4)
            begin
                send_item(sgb_pkg::OP_LOAD_WEIGHT, 5'($urandom_range(17, 31)),
                          16'($urandom), rand_px(0));
            end
            else if (pick < 6)
            begin
                send_item(sgb_pkg::OP_DRAIN, 5'($urandom), 16'($urandom), rand_px(0));
            end
            else if (pick < 7)
            begin
                send_item(sgb_pkg::OP_LOAD_WEIGHT, 5'($urandom_range(0, 2 * re)),
                          rand_weight(wmode, 2 * re + 1), rand_px(0));
            end
            send_item(sgb_pkg::OP_PIXEL, 5'($urandom), 16'($urandom), rand_px(pmode));
        end
        // with radius at least one and width at least two some outputs are
        // still due, so one more pixel is dropped and acts as a drain
        if (re >= 1 && we >= 2 && $urandom_range(0, 2) == 0)
        begin
            send_item(sgb_pkg::OP_PIXEL, 5'($urandom), 16'($urandom), rand_px(0));
        end
        while (frames_done == start)
        begin
            send_item(sgb_pkg::OP_DRAIN, 5'($urandom), 16'($urandom), rand_px(0));
        end
    endtask

    initial
    begin
        int rad, w, h, start;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= sgb_pkg::CFG_RADIUS;
        cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.operation <= sgb_pkg::OP_LOAD_WEIGHT;
        in_ch.tap_index <= '0;
        in_ch.weight_value <= '0;
        in_ch.red_in <= '0;
        in_ch.green_in <= '0;
        in_ch.blue_in <= '0;
        in_ch.alpha_in <= '0;
        calm = 1'b0;
        items_sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: 3x2 frame, full-scale weights so that large sums clip
        write_reg(sgb_pkg::CFG_RADIUS, 11'd1);
        write_reg(sgb_pkg::CFG_WIDTH, 11'd3);
        write_reg(sgb_pkg::CFG_HEIGHT, 11'd2);
        cfg_we <= 1'b0;
        send_item(sgb_pkg::OP_DRAIN, 5'd0, 16'd0, 64'd0);
        send_item(OP_UNUSED, 5'h1F, 16'hFFFF, {64{1'b1}});
        send_item(sgb_pkg::OP_LOAD_WEIGHT, 5'h1F, 16'hFFFF, 64'd0);
        send_item(sgb_pkg::OP_LOAD_WEIGHT, 5'd17, 16'h1234, 64'd0);
        for (int t = 0; t < 3; t++)
        begin
            send_item(sgb_pkg::OP_LOAD_WEIGHT, 5'(t), 16'hFFFF, 64'd0);
        end
        start = frames_done;
        send_item(sgb_pkg::OP_PIXEL, 5'd0, 16'd0, 64'h0000_0000_0000_0000);
        send_item(sgb_pkg::OP_PIXEL, 5'd0, 16'd0, {64{1'b1}});
        send_item(sgb_pkg::OP_PIXEL, 5'd0, 16'd0, 64'hFFFF_0000_FFFF_0000);
        send_item(sgb_pkg::OP_PIXEL, 5'd0, 16'd0, 64'h0000_FFFF_0000_FFFF);
        send_item(sgb_pkg::OP_PIXEL, 5'd0, 16'd0, 64'h0000_0000_0000_0001);
        send_item(sgb_pkg::OP_PIXEL, 5'd0, 16'd0, {64{1'b1}});
        send_item(sgb_pkg::OP_PIXEL, 5'd0, 16'd0, 64'h1111_2222_3333_4444);
        while (frames_done == start)
        begin
            send_item(sgb_pkg::OP_DRAIN, 5'd0, 16'd0, 64'd0);
        end
        // extreme single-tap and out-of-range sizes
        run_frame(0, 1, 1, 1, 0);
        run_frame(0, 0, 0, 0, 1);

        // one widest row at the largest radius code
        run_frame(15, 2047, 1, 0, 0);

        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            calm = ($urandom_range(0, 3) == 0);
            rad = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) :
                (($urandom_range(0, 5) == 0) ? $urandom_range(17, 40) :
                 $urandom_range(2, 16));
            h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
            run_frame(rad, w, h, $urandom_range(0, 3), $urandom_range(0, 3));
        end
        calm = 1'b0;
        settle();

        $display("covered %0d frames and %0d items; %0d blurred pixels checked",
                 frames_done, items_sent, results_checked);
        $display("radius codes 0..15, widths 0..2047, heights 0..8, noise and drains mixed in");
        if (fail_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
